/* rtl/fsth_pkg.sv */
`timescale 1ns / 1ps
// Package for the fan step table with hysteresis.
// Holds widths, reset table, field accessors, the controller state type and
// the command and status structs. No dependencies.
package fsth_pkg;

    localparam int LEVEL_COUNT = 7;
    localparam int LEVEL_W     = 3;
    localparam int DUTY_W      = 7;
    localparam int RPM_W       = 13;
    localparam int STEP_W      = 27;
    localparam int CFG_INDEX_W = 3;

    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 7'd100;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL  = LEVEL_W'(LEVEL_COUNT - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

    // Packed fields of one level word.
    localparam int ON_LSB  = 20;
    localparam int OFF_LSB = 13;
    localparam int RPM_LSB = 0;

    typedef logic [STEP_W-1:0] step_word_t;

    localparam step_word_t STEP_RESET [LEVEL_COUNT] = '{
        27'd40960, 27'd30453364, 27'd40005536, 27'd50606484,
        27'd65368768, 27'd80122960, 27'd105412664
    };

    function automatic logic [DUTY_W-1:0] on_point(input step_word_t w);
        on_point = w[ON_LSB +: DUTY_W];
    endfunction

    function automatic logic [DUTY_W-1:0] off_point(input step_word_t w);
        off_point = w[OFF_LSB +: DUTY_W];
    endfunction

    function automatic logic [RPM_W-1:0] rpm_of(input step_word_t w);
        rpm_of = w[RPM_LSB +: RPM_W];
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DOWN,
        ST_UP,
        ST_FINISH
    } fsth_state_t;

    typedef struct packed {
        logic load;
        logic step_down;
        logic step_up;
        logic finish;
    } fsth_cmd_t;

    typedef struct packed {
        logic falling;
        logic rising;
        logic level_top;
        logic down_hit;
        logic up_hit;
        logic cursor_zero;
        logic cursor_top;
        logic out_free;
    } fsth_status_t;

endpackage

/* rtl/fsth_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the fan step table block:
// request, result and configuration write channels. Depends on fsth_pkg.

interface fsth_req_if;
    logic                        valid;
    logic                        ready;
    logic [fsth_pkg::DUTY_W-1:0] duty_percent;

    modport source (output valid, output duty_percent, input ready);
    modport sink (input valid, input duty_percent, output ready);
endinterface

interface fsth_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fsth_pkg::RPM_W-1:0]   target_rpm;
    logic [fsth_pkg::LEVEL_W-1:0] active_level;

    modport source (output valid, output target_rpm, output active_level, input ready);
    modport sink (input valid, input target_rpm, input active_level, output ready);
endinterface

interface fsth_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fsth_pkg::CFG_INDEX_W-1:0] index;
    logic [fsth_pkg::STEP_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/fsth_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the fan step table block.
// Sequences load, level walk and result write; depends on fsth_pkg.
module fsth_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fsth_pkg::fsth_status_t status,
    output fsth_pkg::fsth_cmd_t    cmd
);
    import fsth_pkg::*;

    fsth_state_t state_reg;
    fsth_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.falling)
                        state_next = ST_DOWN;
                    else if (status.rising && !status.level_top)
                        state_next = ST_UP;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_DOWN:
            begin
                // Keep stepping down while the request sits at or below the off point.
                if (!status.down_hit || status.cursor_zero)
                    state_next = ST_FINISH;
            end
            ST_UP:
            begin
                if (!status.up_hit || status.cursor_top)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DOWN:
            begin
                cmd.step_down = 1'b1;
            end
            ST_UP:
            begin
                cmd.step_up = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/fsth_dpath.sv */
`timescale 1ns / 1ps
// Datapath for the fan step table block: step table registers, level and
// request state, walk cursor and the result register. Depends on fsth_pkg.
module fsth_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    fsth_cfg_if.sink                    cfg,
    input  logic [fsth_pkg::DUTY_W-1:0] duty_percent,
    fsth_rsp_if.source                  rsp,
    input  fsth_pkg::fsth_cmd_t         cmd,
    output fsth_pkg::fsth_status_t      status
);
    import fsth_pkg::*;

    step_word_t          step_reg [LEVEL_COUNT];
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic [DUTY_W-1:0]   last_reg;
    logic [DUTY_W-1:0]   last_next;
    logic [DUTY_W-1:0]   req_reg;
    logic [DUTY_W-1:0]   req_next;
    logic [LEVEL_W-1:0]  cursor_reg;
    logic [LEVEL_W-1:0]  cursor_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RPM_W-1:0]    rpm_reg;
    logic [RPM_W-1:0]    rpm_next;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [LEVEL_W-1:0]  out_level_next;

    logic [DUTY_W-1:0]   duty_sat;
    step_word_t          cursor_word;
    step_word_t          level_word;

    assign cfg.ready = 1'b1;

    // Configuration writes; indexes past the table are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVEL_COUNT; i++)
                step_reg[i] <= STEP_RESET[i];
        end
        else if (cfg.valid && (32'(cfg.index) < LEVEL_COUNT))
        begin
            step_reg[cfg.index] <= cfg.data;
        end
    end

    assign duty_sat    = (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;
    assign cursor_word = (32'(cursor_reg) < LEVEL_COUNT) ? step_reg[cursor_reg] : '0;
    assign level_word  = step_reg[level_reg];

    always_comb
    begin
        status             = '0;
        status.falling     = duty_sat < last_reg;
        status.rising      = duty_sat > last_reg;
        status.level_top   = level_reg == TOP_LEVEL;
        status.down_hit    = req_reg <= off_point(cursor_word);
        status.up_hit      = req_reg >= on_point(cursor_word);
        status.cursor_zero = cursor_reg == LEVEL_ZERO;
        status.cursor_top  = cursor_reg == TOP_LEVEL;
        status.out_free    = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        level_next     = level_reg;
        last_next      = last_reg;
        req_next       = req_reg;
        cursor_next    = cursor_reg;
        rpm_next       = rpm_reg;
        out_level_next = out_level_reg;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            req_next  = duty_sat;
            last_next = duty_sat;
            // A falling walk starts at the current level, a rising one above it.
            cursor_next = status.falling ? level_reg : level_reg + LEVEL_W'(1);
        end

        if (cmd.step_down && status.down_hit)
        begin
            // Stepping below level zero clamps at zero.
            level_next  = status.cursor_zero ? LEVEL_ZERO : cursor_reg - LEVEL_W'(1);
            cursor_next = cursor_reg - LEVEL_W'(1);
        end

        if (cmd.step_up && status.up_hit)
        begin
            level_next  = cursor_reg;
            cursor_next = cursor_reg + LEVEL_W'(1);
        end

        if (cmd.finish)
        begin
            rpm_next       = rpm_of(level_word);
            out_level_next = level_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cursor_reg    <= cursor_next;
        rpm_reg       <= rpm_next;
        out_level_reg <= out_level_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.target_rpm   = rpm_reg;
    assign rsp.active_level = out_level_reg;

endmodule

/* rtl/fan_step_table_hysteresis.sv */
`timescale 1ns / 1ps
// Fan level selector with a seven-entry step table and hysteresis. Each request beat
// carries a duty in percent (above 100 reads as 100) and yields one result beat with
// the chosen level and its rpm. A request is loaded first; one that equals the previous
// request or rises while at the top level skips the walk, and any other one walks the
// table level by level over the shared table read, stopping at the first level that
// fails its threshold or at the end of the table. The result register is then written;
// that last step waits while an earlier result is still unread.
// The result register lets the next request in while a result waits.
// Table words (on[26:20], off[19:13], rpm[12:0]) are written on the cfg channel,
// index 0 to 6; other indexes are ignored. Depends on fsth_pkg and fsth_if.
module fan_step_table_hysteresis (
    input  logic       clk,
    input  logic       rst_n,
    fsth_req_if.sink   req,
    fsth_rsp_if.source rsp,
    fsth_cfg_if.sink   cfg
);
    import fsth_pkg::*;

    fsth_cmd_t    cmd;
    fsth_status_t status;

    fsth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fsth_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .duty_percent (req.duty_percent),
        .rsp          (rsp),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* sim/fan_step_table_hysteresis_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for fan_step_table_hysteresis: directed table plus random duty
// requests under several step tables, scored against a local level predictor.
// Depends on fsth_pkg, fsth_if and the block itself.
module fan_step_table_hysteresis_test;
    import fsth_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [RPM_W-1:0]   rpm;
        logic [LEVEL_W-1:0] level;
    } fan_result_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               typed;
        logic [RPM_W-1:0]   rpm;
        logic [LEVEL_W-1:0] level;
    } duty_row_t;

    typedef enum int {
        TBL_RESET,
        TBL_ZERO,
        TBL_ONES,
        TBL_LADDER,
        TBL_NOISE
    } table_kind_t;

    localparam int DIR_ROWS = 23;
    // Walk of the reset table: saturation, top clamp, bottom clamp, hysteresis edges.
    localparam duty_row_t DUTY_ROWS [DIR_ROWS] = '{
        '{7'd0,   1'b1, 13'd0,    3'd0},
        '{7'd29,  1'b1, 13'd3700, 3'd1},
        '{7'd127, 1'b1, 13'd6200, 3'd6},
        '{7'd100, 1'b1, 13'd6200, 3'd6},
        '{7'd0,   1'b1, 13'd0,    3'd0},
        '{7'd101, 1'b1, 13'd6200, 3'd6},
        '{7'd66,  1'b1, 13'd5200, 3'd5},
        '{7'd67,  1'b1, 13'd5200, 3'd5},
        '{7'd52,  1'b1, 13'd4800, 3'd4},
        '{7'd53,  1'b1, 13'd4800, 3'd4},
        '{7'd76,  1'b1, 13'd5200, 3'd5},
        '{7'd75,  1'b1, 13'd5200, 3'd5},
        '{7'd0,   1'b1, 13'd0,    3'd0},
        '{7'd5,   1'b1, 13'd0,    3'd0},
        '{7'd4,   1'b1, 13'd0,    3'd0},
        '{7'd28,  1'b0, 13'd0,    3'd0},
        '{7'd38,  1'b1, 13'd4000, 3'd2},
        '{7'd19,  1'b1, 13'd3700, 3'd1},
        '{7'd64,  1'b1, 13'd4800, 3'd4},
        '{7'd85,  1'b0, 13'd0,    3'd0},
        '{7'd1,   1'b0, 13'd0,    3'd0},
        '{7'd42,  1'b0, 13'd0,    3'd0},
        '{7'd127, 1'b0, 13'd0,    3'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fsth_req_if req_ch ();
    fsth_rsp_if rsp_ch ();
    fsth_cfg_if cfg_ch ();

    fan_step_table_hysteresis u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Local copy of the table and the selector state.
    step_word_t         step_table [LEVEL_COUNT];
    logic [LEVEL_W-1:0] fan_level;
    logic [DUTY_W-1:0]  prev_duty;

    fan_result_t expected_results [$];
    bit req_idle = 1'b1;
    bit rsp_idle = 1'b1;
    int n_requests = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_tables = 1;
    int n_fail = 0;
    int quiet_cycles = 0;

    function automatic int draw_wait(input bit idle_on);
        return idle_on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    function automatic fan_result_t predict_fan(input logic [DUTY_W-1:0] duty);
        logic [DUTY_W-1:0] want;
        int lvl;
        fan_result_t res;
        want = (duty > DUTY_MAX) ? DUTY_MAX : duty;
        lvl = int'(fan_level);
        if (lvl > LEVEL_COUNT - 1)
            lvl = LEVEL_COUNT - 1;
        if (want < prev_duty)
        begin
            for (int k = lvl; k >= 0; k--)
            begin
                if (want <= step_table[k][OFF_LSB +: DUTY_W])
                    lvl = k - 1;
                else
                    break;
            end
        end
        else if (want > prev_duty)
        begin
            for (int k = lvl + 1; k < LEVEL_COUNT; k++)
            begin
                if (want >= step_table[k][ON_LSB +: DUTY_W])
                    lvl = k;
                else
                    break;
            end
        end
        if (lvl < 0)
            lvl = 0;
        fan_level = LEVEL_W'(lvl);
        prev_duty = want;
        res.rpm = step_table[fan_level][RPM_LSB +: RPM_W];
        res.level = fan_level;
        return res;
    endfunction

    // Mostly in-range requests, with repeats and values right at the thresholds.
    function automatic logic [DUTY_W-1:0] pick_duty();
        int r;
        int d;
        int lvl;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            d = $urandom_range(0, 100);
        end
        else if (r < 55)
        begin
            d = prev_duty;
        end
        else if (r < 80)
        begin
            lvl = $urandom_range(0, LEVEL_COUNT - 1);
            if ($urandom_range(0, 1) == 0)
                d = step_table[lvl][ON_LSB +: DUTY_W];
            else
                d = step_table[lvl][OFF_LSB +: DUTY_W];
            d = d + int'($urandom_range(0, 2)) - 1;
            if (d < 0)
                d = 0;
            if (d > 127)
                d = 127;
        end
        else if (r < 90)
        begin
            d = $urandom_range(101, 127);
        end
        else
        begin
            d = ($urandom_range(0, 1) == 0) ? 0 : 100;
        end
        return DUTY_W'(d);
    endfunction

    task automatic send_duty(input logic [DUTY_W-1:0] duty, input bit typed,
                             input fan_result_t typed_res);
        int gap;
        fan_result_t pred;
        gap = draw_wait(req_idle);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.duty_percent <= duty;
        do @(posedge clk); while (!req_ch.ready);
        pred = predict_fan(duty);
        expected_results.push_back(typed ? typed_res : pred);
        n_requests++;
    endtask

    // Leaves valid high so that back-to-back writes run without a gap; the caller drops it.
    task automatic write_step(input logic [CFG_INDEX_W-1:0] idx, input step_word_t word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= word;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx < LEVEL_COUNT)
            step_table[idx] = word;
        n_writes++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_table(input table_kind_t kind);
        step_word_t word;
        int on_pt;
        int off_pt;
        on_pt = 0;
        // The spare index must leave the table untouched.
        write_step(SPARE_INDEX, STEP_W'($urandom()));
        for (int k = 0; k < LEVEL_COUNT; k++)
        begin
            case (kind)
                TBL_RESET:  word = STEP_RESET[k];
                TBL_ZERO:   word = '0;
                TBL_ONES:   word = '1;
                TBL_LADDER:
                begin
                    if (k > 0)
                        on_pt = on_pt + int'($urandom_range(1, 18));
                    if (on_pt > 127)
                        on_pt = 127;
                    off_pt = (k == 0) ? int'($urandom_range(0, 10))
                                      : on_pt - int'($urandom_range(1, 20));
                    if (off_pt < 0)
                        off_pt = 0;
                    word = {DUTY_W'(on_pt), DUTY_W'(off_pt), RPM_W'($urandom())};
                end
                default:    word = STEP_W'($urandom());
            endcase
            write_step(k[CFG_INDEX_W-1:0], word);
        end
        cfg_ch.valid <= 1'b0;
        n_tables++;
    endtask

    task automatic run_phase(input table_kind_t kind, input int count);
        drain_results();
        load_table(kind);
        req_idle = ($urandom_range(0, 2) != 0);
        rsp_idle = ($urandom_range(0, 2) != 0);
        repeat (count)
            send_duty(pick_duty(), 1'b0, '0);
    endtask

    // Result side: random stalls, and every beat checked against the oldest expectation.
    initial
    begin
        int stall;
        fan_result_t want;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = draw_wait(rsp_idle);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: target_rpm %0d, active_level %0d",
                       rsp_ch.target_rpm, rsp_ch.active_level);
                n_fail++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (rsp_ch.target_rpm !== want.rpm)
                begin
                    $error("target_rpm: expected %0d, got %0d", want.rpm, rsp_ch.target_rpm);
                    n_fail++;
                end
                if (rsp_ch.active_level !== want.level)
                begin
                    $error("active_level: expected %0d, got %0d",
                           want.level, rsp_ch.active_level);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        duty_row_t row;
        req_ch.valid = 1'b0;
        req_ch.duty_percent = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int k = 0; k < LEVEL_COUNT; k++)
            step_table[k] = STEP_RESET[k];
        fan_level = LEVEL_ZERO;
        prev_duty = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DUTY_ROWS[i];
            send_duty(row.duty, row.typed, '{rpm: row.rpm, level: row.level});
        end

        run_phase(TBL_RESET, 60);
        run_phase(TBL_ZERO, 40);
        run_phase(TBL_ONES, 40);
        repeat (4)
            run_phase(TBL_LADDER, 50);
        repeat (2)
            run_phase(TBL_NOISE, 40);
        run_phase(TBL_RESET, 40);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d duty requests over %0d step tables (%0d register writes).",
                 n_requests, n_tables, n_writes);
        $display("Checked %0d result beats, %0d field mismatches.", n_checked, n_fail);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
